// File: rtl/sit_pkg.sv
// Shared constants and types of the Sampson inlier test.
`default_nettype none

package sit_pkg;

  localparam int FIELD_WIDTH      = 16;
  localparam int INDEX_WIDTH      = 16;
  localparam int CFG_INDEX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH   = 63;
  localparam int THR_WIDTH        = 40;
  localparam logic [THR_WIDTH-1:0] THR_RESET = 40'd42950;

  localparam int COORD_WIDTH_DEFAULT = 16;
  localparam int COEF_WIDTH_DEFAULT  = 21;

  // Q.4 coordinates: the homogeneous 1.0 is 1 << COORD_FRAC
  localparam int COORD_FRAC  = 4;
  // aligns num^2 (Q.56) with threshold * den (Q.80)
  localparam int ALIGN_SHIFT = 24;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_F_ROW0     = 2'd0,
    REG_F_ROW1     = 2'd1,
    REG_F_ROW2     = 2'd2,
    REG_THRESHOLD  = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/sit_match_if.sv
// Input channel: one feature match per transfer.
`default_nettype none

interface sit_match_if;
  logic                              valid;
  logic                              ready;
  logic [sit_pkg::FIELD_WIDTH-1:0]   prev_x;
  logic [sit_pkg::FIELD_WIDTH-1:0]   prev_y;
  logic [sit_pkg::FIELD_WIDTH-1:0]   curr_x;
  logic [sit_pkg::FIELD_WIDTH-1:0]   curr_y;
  logic [sit_pkg::INDEX_WIDTH-1:0]   match_index;

  modport source (
    output valid, prev_x, prev_y, curr_x, curr_y, match_index,
    input  ready
  );
  modport sink (
    input  valid, prev_x, prev_y, curr_x, curr_y, match_index,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/sit_result_if.sv
// Output channel: inlier verdict and echoed index per transfer.
`default_nettype none

interface sit_result_if;
  logic                              valid;
  logic                              ready;
  logic [sit_pkg::INDEX_WIDTH-1:0]   result_index;
  logic                              is_inlier;

  modport source (
    output valid, result_index, is_inlier,
    input  ready
  );
  modport sink (
    input  valid, result_index, is_inlier,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/sampson_inlier_test_core.sv
// Sampson-distance epipolar inlier test, eleven-stage pipeline.
//
// Takes one match per clock when the result side is not stalled and returns one
// verdict per match, in order. Every multiplier is its own pipelined unit (widest
// are the 28x28 halves of num^2 at default widths), so throughput is one item per
// cycle without backpressure. Each stage holds its own valid bit and loads whenever
// it is empty or the next stage moves, so empty slots are squeezed out under
// backpressure and the input stays open while a finished verdict waits, until every
// stage is full. F and the threshold must be written while no match is in flight.
`default_nettype none

module sampson_inlier_test_core #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEFAULT,
  parameter int COEF_WIDTH  = sit_pkg::COEF_WIDTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  wr_en,
  input  wire logic [sit_pkg::CFG_INDEX_WIDTH-1:0]   wr_index,
  input  wire logic [sit_pkg::CFG_DATA_WIDTH-1:0]    wr_data,
  sit_match_if.sink                                  feature,
  sit_result_if.source                               result
);

  localparam int NS   = 11;
  localparam int CW   = COEF_WIDTH;
  localparam int CU   = (COORD_WIDTH < sit_pkg::FIELD_WIDTH) ? COORD_WIDTH
                                                            : sit_pkg::FIELD_WIDTH;
  localparam int XW   = COORD_WIDTH + 1;          // signed coordinate
  localparam int PW   = CW + XW;                  // coefficient * coordinate
  localparam int AW   = CW + COORD_WIDTH + 2;     // signed a, b
  localparam int AM   = AW - 1;                   // magnitude of a, b
  localparam int SL   = (AM + 1) / 2;
  localparam int SH   = AM - SL;
  localparam int HHW  = 2 * SH;
  localparam int HLW  = SH + SL;
  localparam int LLW  = 2 * SL;
  localparam int SQW  = 2 * AM;
  localparam int DW   = 2 * AM + 2;               // sum of four squares
  localparam int NW   = CW + 2 * COORD_WIDTH + 4; // signed num
  localparam int NM   = NW - 1;
  localparam int NL   = (NM + 1) / 2;
  localparam int NH   = NM - NL;
  localparam int NSW  = 2 * NM;                   // num^2
  localparam int TW   = sit_pkg::THR_WIDTH;
  localparam int TL   = TW / 2;
  localparam int TH   = TW - TL;
  localparam int DC   = (DW + 2) / 3;             // den chunk for threshold * den
  localparam int DPW  = 3 * DC;
  localparam int RPL  = TL + DC;
  localparam int RPH  = TH + DC;
  localparam int RSL  = TL + DPW;
  localparam int RSH  = TH + DPW;
  localparam int LSW  = NSW + sit_pkg::ALIGN_SHIFT;
  localparam int RW   = TW + DPW;
  localparam int CMPW = (LSW > RW) ? LSW : RW;

  // configuration
  logic [sit_pkg::CFG_DATA_WIDTH-1:0] f_rows [3];
  logic [TW-1:0]                      thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_rows[0] <= '0;
      f_rows[1] <= '0;
      f_rows[2] <= '0;
      thr       <= sit_pkg::THR_RESET;
    end else if (wr_en) begin
      case (sit_pkg::cfg_reg_t'(wr_index))
        sit_pkg::REG_F_ROW0:    f_rows[0] <= wr_data;
        sit_pkg::REG_F_ROW1:    f_rows[1] <= wr_data;
        sit_pkg::REG_F_ROW2:    f_rows[2] <= wr_data;
        sit_pkg::REG_THRESHOLD: thr       <= wr_data[TW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] fm [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        fm[i][j] = f_rows[i][j*CW +: CW];
      end
    end
  end

  // pipeline control
  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = ~vld[NS-1] | result.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = ~vld[k] | adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= feature.valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  logic [sit_pkg::INDEX_WIDTH-1:0] idx [NS];

  always_ff @(posedge clk) begin
    if (adv[0]) idx[0] <= feature.match_index;
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) idx[k] <= idx[k-1];
    end
  end

  // stage 0: capture coordinates
  logic [COORD_WIDTH-1:0] p_x0, p_y0, c_x0, c_y0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p_x0 <= COORD_WIDTH'(feature.prev_x[CU-1:0]);
      p_y0 <= COORD_WIDTH'(feature.prev_y[CU-1:0]);
      c_x0 <= COORD_WIDTH'(feature.curr_x[CU-1:0]);
      c_y0 <= COORD_WIDTH'(feature.curr_y[CU-1:0]);
    end
  end

  logic signed [XW-1:0] xs1 [2];
  logic signed [XW-1:0] xs2 [2];

  assign xs1[0] = $signed({1'b0, p_x0});
  assign xs1[1] = $signed({1'b0, p_y0});
  assign xs2[0] = $signed({1'b0, c_x0});
  assign xs2[1] = $signed({1'b0, c_y0});

  // stage 1: coefficient products (the homogeneous column is a shift, added later)
  logic signed [PW-1:0]   pa [3][2];
  logic signed [PW-1:0]   pb [2][2];
  logic [COORD_WIDTH-1:0] c_x1, c_y1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 2; j++) begin
          pa[i][j] <= PW'(fm[i][j]) * PW'(xs1[j]);
        end
      end
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          pb[i][j] <= PW'(fm[j][i]) * PW'(xs2[j]);
        end
      end
      c_x1 <= c_x0;
      c_y1 <= c_y0;
    end
  end

  // stage 2: a = F x1, b = F^T x2
  logic signed [AW-1:0]   av [3];
  logic signed [AW-1:0]   bv [2];
  logic [COORD_WIDTH-1:0] c_x2, c_y2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        av[i] <= AW'(pa[i][0]) + AW'(pa[i][1])
               + (AW'(fm[i][2]) <<< sit_pkg::COORD_FRAC);
      end
      for (int i = 0; i < 2; i++) begin
        bv[i] <= AW'(pb[i][0]) + AW'(pb[i][1])
               + (AW'(fm[2][i]) <<< sit_pkg::COORD_FRAC);
      end
      c_x2 <= c_x1;
      c_y2 <= c_y1;
    end
  end

  logic signed [AW-1:0] sv [4];

  assign sv[0] = av[0];
  assign sv[1] = av[1];
  assign sv[2] = bv[0];
  assign sv[3] = bv[1];

  // stage 3: magnitudes for the squares
  logic [AM-1:0]          mag [4];
  logic signed [AW-1:0]   a3 [3];
  logic [COORD_WIDTH-1:0] c_x3, c_y3;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int k = 0; k < 4; k++) begin
        mag[k] <= sv[k][AW-1] ? AM'(-sv[k]) : AM'(sv[k]);
      end
      for (int i = 0; i < 3; i++) begin
        a3[i] <= av[i];
      end
      c_x3 <= c_x2;
      c_y3 <= c_y2;
    end
  end

  logic signed [XW-1:0] xs3 [2];

  assign xs3[0] = $signed({1'b0, c_x3});
  assign xs3[1] = $signed({1'b0, c_y3});

  // stage 4: numerator terms and half-word square partials
  logic signed [NW-1:0] nt [2];
  logic signed [AW-1:0] a2_4;
  logic [HHW-1:0]       hh [4];
  logic [HLW-1:0]       hl [4];
  logic [LLW-1:0]       ll [4];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < 2; i++) begin
        nt[i] <= NW'(a3[i]) * NW'(xs3[i]);
      end
      a2_4 <= a3[2];
      for (int k = 0; k < 4; k++) begin
        hh[k] <= HHW'(mag[k][AM-1:SL]) * HHW'(mag[k][AM-1:SL]);
        hl[k] <= HLW'(mag[k][AM-1:SL]) * HLW'(mag[k][SL-1:0]);
        ll[k] <= LLW'(mag[k][SL-1:0])  * LLW'(mag[k][SL-1:0]);
      end
    end
  end

  // stage 5: num = x2^T a, squares
  logic signed [NW-1:0] num;
  logic [SQW-1:0]       sq [4];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      num <= nt[0] + nt[1] + (NW'(a2_4) <<< sit_pkg::COORD_FRAC);
      for (int k = 0; k < 4; k++) begin
        sq[k] <= (SQW'(hh[k]) << (2 * SL)) + (SQW'(hl[k]) << (SL + 1)) + SQW'(ll[k]);
      end
    end
  end

  // stage 6: |num| and the denominator
  logic [NM-1:0] nmag;
  logic [DW-1:0] den;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      nmag <= num[NW-1] ? NM'(-num) : NM'(num);
      den  <= DW'(sq[0]) + DW'(sq[1]) + DW'(sq[2]) + DW'(sq[3]);
    end
  end

  logic [DPW-1:0] dpad;

  assign dpad = DPW'(den);

  // stage 7: partial products of num^2 and threshold * den
  logic [2*NH-1:0]  nhh;
  logic [NH+NL-1:0] nhl;
  logic [2*NL-1:0]  nll;
  logic [RPL-1:0]   rpl [3];
  logic [RPH-1:0]   rph [3];

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      nhh <= (2*NH)'(nmag[NM-1:NL]) * (2*NH)'(nmag[NM-1:NL]);
      nhl <= (NH+NL)'(nmag[NM-1:NL]) * (NH+NL)'(nmag[NL-1:0]);
      nll <= (2*NL)'(nmag[NL-1:0]) * (2*NL)'(nmag[NL-1:0]);
      for (int m = 0; m < 3; m++) begin
        rpl[m] <= RPL'(thr[TL-1:0])  * RPL'(dpad[m*DC +: DC]);
        rph[m] <= RPH'(thr[TW-1:TL]) * RPH'(dpad[m*DC +: DC]);
      end
    end
  end

  // stage 8: gather partials
  logic [NSW-1:0] nsq;
  logic [RSL-1:0] rsl;
  logic [RSH-1:0] rsh;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      nsq <= (NSW'(nhh) << (2 * NL)) + (NSW'(nhl) << (NL + 1)) + NSW'(nll);
      rsl <= RSL'(rpl[0]) + (RSL'(rpl[1]) << DC) + (RSL'(rpl[2]) << (2 * DC));
      rsh <= RSH'(rph[0]) + (RSH'(rph[1]) << DC) + (RSH'(rph[2]) << (2 * DC));
    end
  end

  // stage 9: threshold * den
  logic [NSW-1:0]  nsq9;
  logic [CMPW-1:0] rhs;

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      nsq9 <= nsq;
      rhs  <= CMPW'(rsl) + (CMPW'(rsh) << TL);
    end
  end

  // stage 10: cross-multiplied compare; zero den never passes
  logic inlier;

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      inlier <= (CMPW'(nsq9) << sit_pkg::ALIGN_SHIFT) < rhs;
    end
  end

  // hold the input closed while in reset
  assign feature.ready       = adv[0] & ~rst;
  assign result.valid        = vld[NS-1];
  assign result.result_index = idx[NS-1];
  assign result.is_inlier    = inlier;

endmodule

`default_nettype wire

// File: verif/sampson_inlier_test_core_test.sv
// Self-checking bench for the Sampson inlier test core: directed table, then random phases.
`default_nettype none

module sampson_inlier_test_core_test;

  localparam int CW          = sit_pkg::COEF_WIDTH_DEFAULT;
  localparam int FW          = sit_pkg::FIELD_WIDTH;
  localparam int IW          = sit_pkg::INDEX_WIDTH;
  localparam int DWID        = sit_pkg::CFG_DATA_WIDTH;
  localparam int TWID        = sit_pkg::THR_WIDTH;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int COEF_MAX    = (1 << (CW - 1)) - 1;
  localparam int COEF_MIN    = -(1 << (CW - 1));

  typedef struct {
    logic [IW-1:0] idx;
    bit            inlier;
  } verdict_t;

  typedef struct {
    bit                  is_write;
    sit_pkg::cfg_reg_t   target;
    logic [DWID-1:0]     value;
    logic [FW-1:0]       px, py, cx, cy;
    logic [IW-1:0]       idx;
    bit                  typed;
    bit                  verdict;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  sit_pkg::cfg_reg_t wr_index;
  logic [DWID-1:0] wr_data;

  sit_match_if  match_ch ();
  sit_result_if verdict_ch ();

  sampson_inlier_test_core uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .feature  (match_ch),
    .result   (verdict_ch)
  );

  always #4 clk = ~clk;

  // copy of the configuration as the block should hold it
  logic [DWID-1:0] f_shadow [3];
  logic [TWID-1:0] thr_shadow;

  verdict_t  verdicts_due [$];
  plan_row_t plan [$];

  int  failures       = 0;
  int  matches_sent   = 0;
  int  verdicts_seen  = 0;
  int  inliers_seen   = 0;
  int  settings_used  = 0;
  int  cycles         = 0;
  int  burst_left     = 0;
  bit  steady         = 1'b0;
  bit  bus_live       = 1'b0;
  logic hold_request;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d verdicts outstanding", cycles,
               verdicts_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic flag_failure(input string msg);
    if (failures < 10) $display("%s", msg);
    failures++;
  endtask

  function automatic bit predict_inlier(input logic [FW-1:0] px, py, cx, cy);
    longint fm [3][3];
    longint p [3];
    longint q [3];
    longint a [3];
    longint b [3];
    longint num;
    logic signed [CW-1:0]  c;
    logic signed [255:0]   w, num_sq, den, rhs;
    p[0] = longint'(px);
    p[1] = longint'(py);
    p[2] = longint'(1) << sit_pkg::COORD_FRAC;
    q[0] = longint'(cx);
    q[1] = longint'(cy);
    q[2] = longint'(1) << sit_pkg::COORD_FRAC;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c = f_shadow[i][j*CW +: CW];
        fm[i][j] = longint'(c);
      end
    end
    for (int i = 0; i < 3; i++) begin
      a[i] = 0;
      b[i] = 0;
      for (int j = 0; j < 3; j++) begin
        a[i] += fm[i][j] * p[j];
        b[i] += fm[j][i] * q[j];
      end
    end
    num = q[0] * a[0] + q[1] * a[1] + q[2] * a[2];
    w = 256'(num);
    num_sq = (w * w) <<< sit_pkg::ALIGN_SHIFT;
    den = 0;
    for (int i = 0; i < 2; i++) begin
      w = 256'(a[i]);
      den += w * w;
      w = 256'(b[i]);
      den += w * w;
    end
    w = 256'(thr_shadow);
    rhs = w * den;
    // a zero denominator gives rhs = 0, so the strict compare fails by itself
    return num_sq < rhs;
  endfunction

  function automatic logic [DWID-1:0] pack_row(input int c0, c1, c2);
    return {c2[CW-1:0], c1[CW-1:0], c0[CW-1:0]};
  endfunction

  function automatic logic [FW-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[FW-1:0];
  endfunction

  task automatic add_write(input sit_pkg::cfg_reg_t target, input logic [DWID-1:0] value);
    plan_row_t r;
    r = '{target: sit_pkg::REG_F_ROW0, default: '0};
    r.is_write = 1'b1;
    r.target   = target;
    r.value    = value;
    plan = {plan, r};
  endtask

  task automatic add_match(input logic [FW-1:0] px, py, cx, cy,
                           input logic [IW-1:0] idx,
                           input bit typed, input bit verdict);
    plan_row_t r;
    r = '{target: sit_pkg::REG_F_ROW0, default: '0};
    r.px      = px;
    r.py      = py;
    r.cx      = cx;
    r.cy      = cy;
    r.idx     = idx;
    r.typed   = typed;
    r.verdict = verdict;
    plan = {plan, r};
  endtask

  // drop valid, wait until every verdict is back, then leave the pipe empty
  task automatic settle();
    if (bus_live) begin
      match_ch.valid <= 1'b0;
      bus_live = 1'b0;
    end
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input sit_pkg::cfg_reg_t target, input logic [DWID-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= target;
    wr_data  <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    if (target == sit_pkg::REG_THRESHOLD) thr_shadow = value[TWID-1:0];
    else f_shadow[target] = value;
    @(posedge clk);
  endtask

  task automatic send_match(input logic [FW-1:0] px, py, cx, cy,
                            input logic [IW-1:0] idx,
                            input bit typed, input bit verdict);
    verdict_t v;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0 && bus_live) begin
        match_ch.valid <= 1'b0;
        bus_live = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    match_ch.valid       <= 1'b1;
    match_ch.prev_x      <= px;
    match_ch.prev_y      <= py;
    match_ch.curr_x      <= cx;
    match_ch.curr_y      <= cy;
    match_ch.match_index <= idx;
    bus_live = 1'b1;
    do @(posedge clk); while (!match_ch.ready);
    v.idx    = idx;
    v.inlier = typed ? verdict : predict_inlier(px, py, cx, cy);
    verdicts_due = {verdicts_due, v};
    matches_sent++;
  endtask

  // result side: check every transfer, stall on a pattern of its own
  initial begin
    int mode, mode_left, tick, held;
    bit hold_done, ready_next;
    verdict_t exp_v;
    mode = 0;
    mode_left = 0;
    tick = 0;
    held = 0;
    hold_done = 1'b0;
    verdict_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (!rst && verdict_ch.valid && verdict_ch.ready) begin
        if (verdicts_due.size() == 0) begin
          flag_failure($sformatf("Unexpected verdict: index %h inlier %0d with none pending",
                                 verdict_ch.result_index, verdict_ch.is_inlier));
        end else begin
          exp_v = verdicts_due.pop_front();
          verdicts_seen++;
          if (verdict_ch.is_inlier === 1'b1) inliers_seen++;
          if (verdict_ch.result_index !== exp_v.idx || verdict_ch.is_inlier !== exp_v.inlier)
            flag_failure($sformatf(
              "Mismatch: expected index %h inlier %0d, got index %h inlier %0d",
              exp_v.idx, exp_v.inlier, verdict_ch.result_index, verdict_ch.is_inlier));
        end
      end
      if (hold_request && !hold_done) begin
        // hold off long enough for the pipeline to fill and close its input
        ready_next = 1'b0;
        held++;
        if (held == HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (mode)
          0: ready_next = 1'b1;
          1: ready_next = 1'($urandom_range(0, 1));
          2: ready_next = ($urandom_range(0, 3) == 0);
          default: ready_next = (tick % 8 != 5);
        endcase
      end
      verdict_ch.ready <= ready_next;
    end
  end

  initial begin
    int kind, scale, along, off;
    int cm [3][3];
    logic [FW-1:0] px, py, cx, cy;
    logic [DWID-1:0] raw;
    logic [TWID-1:0] thr;
    rst                  <= 1'b1;
    wr_en                <= 1'b0;
    wr_index             <= sit_pkg::REG_F_ROW0;
    wr_data              <= '0;
    match_ch.valid       <= 1'b0;
    match_ch.prev_x      <= '0;
    match_ch.prev_y      <= '0;
    match_ch.curr_x      <= '0;
    match_ch.curr_y      <= '0;
    match_ch.match_index <= '0;
    hold_request         <= 1'b0;
    for (int i = 0; i < 3; i++) f_shadow[i] = '0;
    thr_shadow = sit_pkg::THR_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // F is zero after reset: no denominator, never an inlier
    add_match(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    add_match(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    add_match(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0001, 1'b1, 1'b0);
    // horizontal baseline, widest threshold; ignored threshold bits set
    add_write(sit_pkg::REG_THRESHOLD, '1);
    add_write(sit_pkg::REG_F_ROW1, pack_row(0, 0, -COEF_MAX));
    add_write(sit_pkg::REG_F_ROW2, pack_row(0, COEF_MAX, 0));
    add_match(16'h0100, 16'h0200, 16'h0300, 16'h0200, 16'h0002, 1'b1, 1'b1);
    add_match(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0003, 1'b1, 1'b1);
    add_match(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0004, 1'b1, 1'b1);
    add_match(16'h0010, 16'h0000, 16'h0010, 16'hFFFF, 16'h0005, 1'b0, 1'b0);
    add_match(16'h0100, 16'h0200, 16'h0100, 16'h0203, 16'h0006, 1'b0, 1'b0);
    // zero threshold rejects even a perfect match
    add_write(sit_pkg::REG_THRESHOLD, '0);
    add_match(16'h0100, 16'h0200, 16'h0300, 16'h0200, 16'h0007, 1'b1, 1'b0);
    add_match(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0008, 1'b1, 1'b0);
    // only the bottom-right coefficient: zero denominator with nonzero residual
    add_write(sit_pkg::REG_THRESHOLD, '1);
    add_write(sit_pkg::REG_F_ROW0, '0);
    add_write(sit_pkg::REG_F_ROW1, '0);
    add_write(sit_pkg::REG_F_ROW2, pack_row(0, 0, 12345));
    add_match(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0009, 1'b1, 1'b0);
    add_match(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h000A, 1'b1, 1'b0);
    // coefficient extremes
    add_write(sit_pkg::REG_F_ROW0, pack_row(COEF_MIN, COEF_MIN, COEF_MIN));
    add_write(sit_pkg::REG_F_ROW1, pack_row(COEF_MIN, COEF_MIN, COEF_MIN));
    add_write(sit_pkg::REG_F_ROW2, pack_row(COEF_MIN, COEF_MIN, COEF_MIN));
    add_match(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h000B, 1'b0, 1'b0);
    add_match(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h000C, 1'b0, 1'b0);
    add_write(sit_pkg::REG_F_ROW0, pack_row(COEF_MAX, COEF_MAX, COEF_MAX));
    add_write(sit_pkg::REG_F_ROW1, pack_row(COEF_MAX, COEF_MAX, COEF_MAX));
    add_write(sit_pkg::REG_F_ROW2, pack_row(COEF_MAX, COEF_MAX, COEF_MAX));
    add_match(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h000D, 1'b0, 1'b0);
    add_match(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h000E, 1'b0, 1'b0);

    foreach (plan[k]) begin
      if (plan[k].is_write) begin
        settle();
        write_reg(plan[k].target, plan[k].value);
        settings_used++;
      end else begin
        send_match(plan[k].px, plan[k].py, plan[k].cx, plan[k].cy, plan[k].idx,
                   plan[k].typed, plan[k].verdict);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      kind = $urandom_range(0, 3);
      steady = (phase == 1) || ($urandom_range(0, 3) == 0);
      scale = $urandom_range(1, COEF_MAX - 64);
      if ($urandom_range(0, 1) != 0) scale = -scale;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          cm[i][j] = (kind == 2) ? int'($urandom_range(0, 64)) - 32 : 0;
      // kinds 0 and 2: horizontal baseline; kind 1: vertical baseline
      if (kind == 1) begin
        cm[0][2] += scale;
        cm[2][0] -= scale;
      end else begin
        cm[1][2] -= scale;
        cm[2][1] += scale;
      end
      for (int i = 0; i < 3; i++) begin
        raw = DWID'({$urandom, $urandom});
        write_reg(sit_pkg::cfg_reg_t'(i),
                  (kind == 3) ? raw : pack_row(cm[i][0], cm[i][1], cm[i][2]));
      end
      case ($urandom_range(0, 7))
        0: thr = '0;
        1: thr = '1;
        2: thr = TWID'({$urandom, $urandom});
        default: thr = TWID'($urandom_range(0, 1 << 29));
      endcase
      raw = DWID'({$urandom, $urandom});
      write_reg(sit_pkg::REG_THRESHOLD, {raw[DWID-1:TWID], thr});
      settings_used++;
      if (phase == 1) hold_request <= 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        px = FW'($urandom_range(0, 65535));
        py = FW'($urandom_range(0, 65535));
        if (kind == 3 || $urandom_range(0, 4) == 0) begin
          cx = FW'($urandom_range(0, 65535));
          cy = FW'($urandom_range(0, 65535));
        end else begin
          // move along the epipolar line, small error across it
          along = $urandom_range(0, 8192) - 4096;
          off   = $urandom_range(0, 32) - 16;
          if (kind == 1) begin
            cx = clamp_coord(int'(px) + off);
            cy = clamp_coord(int'(py) + along);
          end else begin
            cx = clamp_coord(int'(px) + along);
            cy = clamp_coord(int'(py) + off);
          end
        end
        send_match(px, py, cx, cy, IW'($urandom_range(0, 65535)), 1'b0, 1'b0);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (verdicts_due.size() != 0)
      flag_failure($sformatf("%0d verdicts never arrived", verdicts_due.size()));
    $display("Covered %0d matches over %0d settings of F and threshold", matches_sent,
             settings_used);
    $display("Checked %0d verdicts (%0d inliers), %0d failures", verdicts_seen,
             inliers_seen, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/sit_pkg.sv
rtl/sit_match_if.sv
rtl/sit_result_if.sv
rtl/sampson_inlier_test_core.sv
verif/sampson_inlier_test_core_test.sv
